FILE: hw/rtl/gdsd_pkg.sv
package gdsd_pkg;

  // Time step limits and thresholds.
  localparam int unsigned DT_W = 7;
  localparam logic [DT_W-1:0] MAX_DT_MS = 7'd100;
  localparam logic [31:0] SMALL_RATE_SQ = 32'd6400;
  localparam int unsigned ACC_SHIFT = 6;

  // Shared multiplier: signed 33 x signed 17.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
  localparam logic [15:0] Q16_ROUND = 16'hFFFF;

  // Serial divider by one thousand, several quotient bits per cycle.
  localparam int unsigned DIV_W = 44;
  localparam int unsigned DIV_DIGITS = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_DIGITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned REM_W = 10;
  localparam logic [REM_W:0] DIVISOR = 11'd1000;

  // Width of the sums before saturation.
  localparam int unsigned SUM_W = 46;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_RETURN     = 3'd1,
    REG_DAMPING    = 3'd2,
    REG_SENS       = 3'd3,
    REG_MAX_DISP   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] return_speed;
    logic [15:0] damping;
    logic [15:0] sensitivity;
    logic [23:0] max_displacement;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        time_ms;
    logic               is_moving;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    if (x[SUM_W-1:31] == '0 || x[SUM_W-1:31] == '1) begin
      return x[31:0];
    end
    return x[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

FILE: hw/rtl/gdsd_in_if.sv
interface gdsd_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        time_ms;
  logic               is_moving;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;

  modport source (output valid, req_type, time_ms, is_moving, gyro_x, gyro_y, input ready);
  modport sink (input valid, req_type, time_ms, is_moving, gyro_x, gyro_y, output ready);
endinterface

FILE: hw/rtl/gdsd_out_if.sv
interface gdsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;

  modport source (output valid, offset_x, offset_y, input ready);
  modport sink (input valid, offset_x, offset_y, output ready);
endinterface

FILE: hw/rtl/gyro_driven_spring_damper_offset_top.sv
// A gyro-driven tick adds an acceleration step and a second divide by one thousand per
// axis to the work of a still or slow-rotating tick.
// The shared multiplier and the serial divider handle one item at a time, and a new tick
// is taken only after the result is handed on. Clear, disabled and first ticks stay idle.
// Reset (rst_n low, synchronous) zeroes time, velocity and position, and loads the
// register defaults.
module gyro_driven_spring_damper_offset_top (
  input  logic              clk,
  input  logic              rst_n,
  gdsd_in_if.sink           in_ch,
  gdsd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import gdsd_pkg::*;

  cfg_t      cfg_r;
  in_item_t  item;
  out_item_t res;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      res_valid;
  logic      res_ready;
  logic      out_valid_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable           <= 1'b1;
      cfg_r.return_speed     <= 16'd3277;
      cfg_r.damping          <= 16'd58982;
      cfg_r.sensitivity      <= 16'd256;
      cfg_r.max_displacement <= 24'd1310720;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:   cfg_r.enable           <= cfg_data[0];
        REG_RETURN:   cfg_r.return_speed     <= cfg_data[15:0];
        REG_DAMPING:  cfg_r.damping          <= cfg_data[15:0];
        REG_SENS:     cfg_r.sensitivity      <= cfg_data[15:0];
        REG_MAX_DISP: cfg_r.max_displacement <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item.req_type  = in_ch.req_type;
  assign item.time_ms   = in_ch.time_ms;
  assign item.is_moving = in_ch.is_moving;
  assign item.gyro_x    = in_ch.gyro_x;
  assign item.gyro_y    = in_ch.gyro_y;

  gdsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  gdsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register: the core hands over a result whenever this stage is free.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.offset_x = out_r.offset_x;
  assign out_ch.offset_y = out_r.offset_y;

endmodule

FILE: hw/rtl/gdsd_div.sv
module gdsd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gdsd_pkg::div_req_t  req,
  output gdsd_pkg::div_rsp_t  rsp
);
  import gdsd_pkg::*;

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Restoring division: the remainder always stays below the divisor,
  // so one compare and subtract settles each quotient bit.
  always_comb begin : digit_steps
    logic [REM_W:0] trial;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      trial   = {rem_nxt, dvd_nxt[DIV_W-1]};
      dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
      if (trial >= DIVISOR) begin
        trial   = trial - DIVISOR;
        quo_nxt = {quo_nxt[DIV_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      end
      rem_nxt = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: hw/rtl/gdsd_core.sv
module gdsd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  gdsd_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  gdsd_pkg::in_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output gdsd_pkg::out_item_t res,
  output gdsd_pkg::div_req_t  div_req,
  input  gdsd_pkg::div_rsp_t  div_rsp
);
  import gdsd_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_SQX    = 15'b000000000000010,
    S_SQY    = 15'b000000000000100,
    S_DECIDE = 15'b000000000001000,
    S_ACC1   = 15'b000000000010000,
    S_ACC2   = 15'b000000000100000,
    S_DIVS   = 15'b000000001000000,
    S_DIVW   = 15'b000000010000000,
    S_DAMP   = 15'b000000100000000,
    S_DAMPW  = 15'b000001000000000,
    S_RET    = 15'b000010000000000,
    S_RETW   = 15'b000100000000000,
    S_VDT    = 15'b001000000000000,
    S_CLAMP  = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [31:0]               prev_time_r;
  logic signed [31:0]        vel_r [2];
  logic signed [31:0]        pos_r [2];
  logic [DT_W-1:0]           dt_r;
  logic                      moving_r;
  logic signed [15:0]        gx_r, gy_r;
  logic [31:0]               sq_r;
  logic                      driven_r;
  logic                      axis_r;
  logic                      phase_r;
  logic                      div_neg_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic                      in_fire;
  logic signed [31:0]        v_cur, p_cur, base;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod, prod_mag, prod_adj;
  logic signed [31:0]        q16;
  logic signed [SUM_W-1:0]   q_ext, q_s;
  logic signed [31:0]        dt_sum, ret_sum, clamp_p, max_m;
  logic [31:0]               sq_total, diff;
  logic                      driven_c;
  logic [DT_W-1:0]           dt_c;
  logic signed [15:0]        g_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res.offset_x = pos_r[0];
  assign res.offset_y = pos_r[1];

  assign v_cur = vel_r[axis_r];
  assign p_cur = pos_r[axis_r];

  assign diff = item.time_ms - prev_time_r;
  assign dt_c = (diff > 32'(MAX_DT_MS)) ? MAX_DT_MS : diff[DT_W-1:0];

  assign sq_total = sq_r + prod_r[31:0];
  assign driven_c = moving_r && (sq_total >= SMALL_RATE_SQ);

  // The x axis is driven by the negated y rate, the y axis by the x rate.
  assign g_acc = axis_r ? gx_r : gy_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQX: begin
        mul_a = {{(MUL_A_W-16){gx_r[15]}}, gx_r};
        mul_b = {gx_r[15], gx_r};
      end
      S_SQY: begin
        mul_a = {{(MUL_A_W-16){gy_r[15]}}, gy_r};
        mul_b = {gy_r[15], gy_r};
      end
      S_ACC1: begin
        mul_a = {{(MUL_A_W-16){g_acc[15]}}, g_acc};
        mul_b = {1'b0, cfg.sensitivity};
      end
      S_ACC2: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt_r};
      end
      S_DAMP: begin
        mul_a = {v_cur[31], v_cur};
        mul_b = {1'b0, cfg.damping};
      end
      S_RET: begin
        mul_a = {p_cur[31], p_cur};
        mul_b = {1'b0, cfg.return_speed};
      end
      S_VDT: begin
        mul_a = {v_cur[31], v_cur};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;

  // The acceleration carries a gain of 64, applied as a shift ahead of the divide.
  assign div_req.start    = (state_r == S_DIVS);
  assign div_req.dividend = phase_r ? prod_mag[DIV_W-1:0]
                                    : {prod_mag[DIV_W-1-ACC_SHIFT:0], ACC_SHIFT'(0)};

  assign q_ext  = {{(SUM_W-DIV_W){1'b0}}, div_rsp.quotient};
  assign q_s    = div_neg_r ? -q_ext : q_ext;
  assign base   = phase_r ? p_cur : v_cur;
  assign dt_sum = sat32({{(SUM_W-32){base[31]}}, base} + q_s);

  // Q0.16 scaling rounds toward zero, so negative products get a bias first.
  assign prod_adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'(Q16_ROUND) : PROD_W'(0));
  assign q16      = prod_adj[47:16];
  assign ret_sum  = sat32({{(SUM_W-32){v_cur[31]}}, v_cur} - {{(SUM_W-32){q16[31]}}, q16});

  assign max_m = {8'b0, cfg.max_displacement};
  always_comb begin
    clamp_p = p_cur;
    if (moving_r) begin
      if (p_cur > max_m) begin
        clamp_p = max_m;
      end else if (p_cur < -max_m) begin
        clamp_p = -max_m;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && item.req_type == REQ_TICK && cfg.enable && prev_time_r != '0) begin
          state_nxt = S_SQX;
        end
      end
      S_SQX:    state_nxt = S_SQY;
      S_SQY:    state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = driven_c ? S_ACC1 : S_RET;
      S_ACC1:   state_nxt = S_ACC2;
      S_ACC2:   state_nxt = S_DIVS;
      S_DIVS:   state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_nxt = phase_r ? S_CLAMP : S_DAMP;
        end
      end
      S_DAMP:   state_nxt = S_DAMPW;
      S_DAMPW:  state_nxt = driven_r ? S_RET : S_VDT;
      S_RET:    state_nxt = S_RETW;
      S_RETW:   state_nxt = driven_r ? S_VDT : S_DAMP;
      S_VDT:    state_nxt = S_DIVS;
      S_CLAMP: begin
        if (!axis_r) begin
          state_nxt = driven_r ? S_ACC1 : S_RET;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_time_r <= '0;
      vel_r[0]    <= '0;
      vel_r[1]    <= '0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      driven_r    <= 1'b0;
      axis_r      <= 1'b0;
      phase_r     <= 1'b0;
      div_neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (item.req_type == REQ_CLEAR) begin
              prev_time_r <= '0;
              vel_r[0]    <= '0;
              vel_r[1]    <= '0;
              pos_r[0]    <= '0;
              pos_r[1]    <= '0;
            end else if (cfg.enable) begin
              prev_time_r <= item.time_ms;
              dt_r        <= dt_c;
              moving_r    <= item.is_moving;
              gx_r        <= item.gyro_x;
              gy_r        <= item.gyro_y;
            end
          end
        end
        S_SQY:    sq_r <= prod_r[31:0];
        S_DECIDE: begin
          driven_r <= driven_c;
          axis_r   <= 1'b0;
        end
        S_ACC2:   phase_r <= 1'b0;
        S_VDT:    phase_r <= 1'b1;
        S_DIVS:   div_neg_r <= prod_r[PROD_W-1] ^ (!phase_r && !axis_r);
        S_DIVW: begin
          if (div_rsp.done) begin
            if (phase_r) begin
              pos_r[axis_r] <= dt_sum;
            end else begin
              vel_r[axis_r] <= dt_sum;
            end
          end
        end
        S_DAMPW:  vel_r[axis_r] <= q16;
        S_RETW:   vel_r[axis_r] <= ret_sum;
        S_CLAMP: begin
          pos_r[axis_r] <= clamp_p;
          axis_r        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_dt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (dt_r <= MAX_DT_MS))
    else $error("time step above the limit while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && item.req_type == REQ_CLEAR) |=>
      (prev_time_r == '0 && vel_r[0] == '0 && vel_r[1] == '0 &&
       pos_r[0] == '0 && pos_r[1] == '0 && state_r == S_IDLE))
    else $error("clear request left state behind");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res.offset_x) && $stable(res.offset_y)))
    else $error("result changed while stalled");

endmodule
